/* hw/rtl/prn_pkg.sv */
package prn_pkg;

    localparam int DATA_W          = 32;
    localparam int DIM_W           = 11;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int MAX_ROW_LEN_DEF = 1024;
    localparam int MAX_ROWS_DEF    = 1024;

    localparam logic [DIM_W-1:0]  ROW_COUNT_RST  = 11'd64;
    localparam logic [DIM_W-1:0]  ROW_LENGTH_RST = 11'd64;
    localparam logic [DATA_W-1:0] INV_D2_RST     = 32'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT      = 2'd0,
        REG_ROW_LENGTH     = 2'd1,
        REG_INV_DX_SQUARED = 2'd2,
        REG_INV_DY_SQUARED = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        MUL_X_HI = 2'd0,
        MUL_X_LO = 2'd1,
        MUL_Y_HI = 2'd2,
        MUL_Y_LO = 2'd3
    } mul_step_t;

    typedef struct packed {
        logic      load;
        logic      win_first;
        logic      win_second;
        logic      win_shift;
        logic      diff;
        logic      mul_en;
        mul_step_t mul_step;
        logic      saturate;
        logic      square;
        logic      sum_add;
        logic      advance;
        logic      sqrt_start;
        logic      out_load;
    } prn_cmd_t;

    typedef struct packed {
        logic col_zero;
        logic interior;
        logic frame_end;
        logic sqrt_done;
        logic out_free;
    } prn_status_t;

endpackage

/* hw/rtl/prn_in_if.sv */
interface prn_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [prn_pkg::DATA_W-1:0]   grid_value;
    logic signed [prn_pkg::DATA_W-1:0]   source_value;

    modport source (output valid, output grid_value, output source_value, input ready);
    modport sink   (input valid, input grid_value, input source_value, output ready);
endinterface

/* hw/rtl/prn_out_if.sv */
interface prn_out_if;
    logic                          valid;
    logic                          ready;
    logic [prn_pkg::DATA_W-1:0]    residual_norm;
    logic                          overflow_seen;

    modport source (output valid, output residual_norm, output overflow_seen, input ready);
    modport sink   (input valid, input residual_norm, input overflow_seen, output ready);
endinterface

/* hw/rtl/prn_ram.sv */
module prn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/prn_sqrt.sv */
module prn_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    localparam int REM_W = 35;

    logic [63:0]      rad_reg,  rad_next;
    logic [REM_W-1:0] rem_reg,  rem_next;
    logic [31:0]      root_reg, root_next;
    logic [4:0]       cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;

    // one result bit per cycle, two radicand bits consumed
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[63:62]};
    assign trial     = {1'b0, root_reg, 2'b01};

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'd31;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[61:0], 2'b00};
            if (rem_shift >= trial)
            begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift;
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* hw/rtl/prn_datapath.sv */
module prn_datapath #(
    parameter int MAX_ROW_LEN = prn_pkg::MAX_ROW_LEN_DEF,
    parameter int MAX_ROWS    = prn_pkg::MAX_ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [prn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [prn_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [prn_pkg::DATA_W-1:0]   grid_value,
    input  logic signed [prn_pkg::DATA_W-1:0]   source_value,
    input  prn_pkg::prn_cmd_t                   cmd,
    output prn_pkg::prn_status_t                status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [prn_pkg::DATA_W-1:0]          residual_norm,
    output logic                                overflow_seen
);

    localparam int DW    = prn_pkg::DATA_W;
    localparam int CW    = $clog2(MAX_ROW_LEN);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int LENW  = CW + 1;
    localparam int RLW   = RW + 1;
    localparam int DIFFW = DW + 2;
    localparam int PRODW = 18 + DW;
    localparam int ACCW  = PRODW + 4;

    localparam logic signed [ACCW-1:0] SAT_HI = ACCW'((64'sd1 <<< (DW - 1)) - 64'sd1);
    localparam logic signed [ACCW-1:0] SAT_LO = -SAT_HI - ACCW'(1);

    logic [prn_pkg::DIM_W-1:0] row_count_reg, row_length_reg;
    logic [DW-1:0]             kx_reg, ky_reg;

    logic [CW-1:0]            col_reg;
    logic [RW-1:0]            row_reg;
    logic signed [DW-1:0]     grid_reg, srcin_reg, up_reg, srcold_reg;
    logic signed [DW-1:0]     w0_reg, w1_reg, w2_reg;
    logic [DIFFW-1:0]         magx_reg, magy_reg;
    logic                     negx_reg, negy_reg;
    logic signed [ACCW-1:0]   acc_reg, acc_next;
    logic [DW-1:0]            emag_reg;
    logic [63:0]              sq_reg, sum_reg;
    logic                     flag_reg;
    logic [DW-1:0]            norm_reg;
    logic                     oflag_reg;
    logic                     ovalid_reg;

    logic [31:0]     rl32, rc32, len32, rows32;
    logic [LENW-1:0] len, next_c;
    logic [RLW-1:0]  rows, next_r;

    logic [DW-1:0]   upper_rd, center_rd, source_rd;
    logic [CW-1:0]   center_raddr;
    logic            store_we;

    logic signed [DIFFW-1:0] dx, dy;
    logic [17:0]             mul_a;
    logic [DW-1:0]           mul_k;
    logic [PRODW-1:0]        prod, part;
    logic                    mul_neg;
    logic signed [ACCW-1:0]  term;
    logic [64:0]             sum_wide;
    logic                    sqrt_done;
    logic [31:0]             sqrt_root;

    // dimensions clamped to 3..max
    assign rl32 = {21'b0, row_length_reg};
    assign rc32 = {21'b0, row_count_reg};
    always_comb
    begin
        if (rl32 < 32'd3)
            len32 = 32'd3;
        else if (rl32 > 32'(MAX_ROW_LEN))
            len32 = 32'(MAX_ROW_LEN);
        else
            len32 = rl32;
        if (rc32 < 32'd3)
            rows32 = 32'd3;
        else if (rc32 > 32'(MAX_ROWS))
            rows32 = 32'(MAX_ROWS);
        else
            rows32 = rc32;
    end
    assign len    = len32[LENW-1:0];
    assign rows   = rows32[RLW-1:0];
    assign next_c = {1'b0, col_reg} + LENW'(1);
    assign next_r = {1'b0, row_reg} + RLW'(1);

    assign status.col_zero  = (col_reg == '0);
    assign status.interior  = (row_reg >= RW'(2)) && (col_reg != '0) && (next_c < len);
    assign status.frame_end = (next_c >= len) && (next_r >= rows);
    assign status.sqrt_done = sqrt_done;
    assign status.out_free  = !ovalid_reg || out_ready;

    always_comb
    begin
        if (cmd.win_first)
            center_raddr = CW'(1);
        else if (col_reg == '0)
            center_raddr = '0;
        else
            center_raddr = next_c[CW-1:0];
    end
    assign store_we = cmd.diff;

    prn_ram #(.WIDTH(DW), .DEPTH(MAX_ROW_LEN)) u_upper (
        .clk(clk), .we(store_we), .waddr(col_reg), .wdata(w1_reg),
        .raddr(col_reg), .rdata(upper_rd)
    );
    prn_ram #(.WIDTH(DW), .DEPTH(MAX_ROW_LEN)) u_center (
        .clk(clk), .we(store_we), .waddr(col_reg), .wdata(grid_reg),
        .raddr(center_raddr), .rdata(center_rd)
    );
    prn_ram #(.WIDTH(DW), .DEPTH(MAX_ROW_LEN)) u_source (
        .clk(clk), .we(store_we), .waddr(col_reg), .wdata(srcin_reg),
        .raddr(col_reg), .rdata(source_rd)
    );

    assign dx = DIFFW'(up_reg) + DIFFW'(grid_reg) - (DIFFW'(w1_reg) <<< 1);
    assign dy = DIFFW'(w0_reg) + DIFFW'(w2_reg) - (DIFFW'(w1_reg) <<< 1);

    // weighted difference in four partial products: |d| split 18/16 bits
    always_comb
    begin
        case (cmd.mul_step)
            prn_pkg::MUL_X_HI:
            begin
                mul_a = magx_reg[DIFFW-1:16];
                mul_k = kx_reg;
                mul_neg = negx_reg;
            end
            prn_pkg::MUL_X_LO:
            begin
                mul_a = {2'b00, magx_reg[15:0]};
                mul_k = kx_reg;
                mul_neg = negx_reg;
            end
            prn_pkg::MUL_Y_HI:
            begin
                mul_a = magy_reg[DIFFW-1:16];
                mul_k = ky_reg;
                mul_neg = negy_reg;
            end
            default:
            begin
                mul_a = {2'b00, magy_reg[15:0]};
                mul_k = ky_reg;
                mul_neg = negy_reg;
            end
        endcase
    end
    assign prod = PRODW'(mul_a) * PRODW'(mul_k);
    assign part = (cmd.mul_step == prn_pkg::MUL_X_HI || cmd.mul_step == prn_pkg::MUL_Y_HI)
                  ? prod : (prod >> 16);
    assign term = mul_neg ? -$signed(ACCW'(part)) : $signed(ACCW'(part));

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.diff)
            acc_next = -ACCW'(srcold_reg);
        else if (cmd.mul_en)
            acc_next = acc_reg + term;
    end

    assign sum_wide = {1'b0, sum_reg} + {1'b0, sq_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg  <= prn_pkg::ROW_COUNT_RST;
            row_length_reg <= prn_pkg::ROW_LENGTH_RST;
            kx_reg         <= prn_pkg::INV_D2_RST;
            ky_reg         <= prn_pkg::INV_D2_RST;
            col_reg        <= '0;
            row_reg        <= '0;
            w0_reg         <= '0;
            w1_reg         <= '0;
            w2_reg         <= '0;
            sum_reg        <= '0;
            flag_reg       <= 1'b0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    prn_pkg::REG_ROW_COUNT:      row_count_reg  <= cfg_data[prn_pkg::DIM_W-1:0];
                    prn_pkg::REG_ROW_LENGTH:     row_length_reg <= cfg_data[prn_pkg::DIM_W-1:0];
                    prn_pkg::REG_INV_DX_SQUARED: kx_reg         <= cfg_data[DW-1:0];
                    prn_pkg::REG_INV_DY_SQUARED: ky_reg         <= cfg_data[DW-1:0];
                    default: ;
                endcase
            end
            if (cmd.win_first)
            begin
                w0_reg <= '0;
                w1_reg <= center_rd;
            end
            if (cmd.win_second)
            begin
                w2_reg <= center_rd;
            end
            if (cmd.win_shift)
            begin
                w0_reg <= w1_reg;
                w1_reg <= w2_reg;
                w2_reg <= (next_c < len) ? center_rd : '0;
            end
            if (cmd.saturate && (acc_reg > SAT_HI || acc_reg < SAT_LO))
            begin
                flag_reg <= 1'b1;
            end
            if (cmd.sum_add)
            begin
                if (sum_wide[64])
                begin
                    sum_reg  <= '1;
                    flag_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= sum_wide[63:0];
                end
            end
            if (cmd.advance)
            begin
                if (next_c >= len)
                begin
                    col_reg <= '0;
                    row_reg <= (next_r >= rows) ? '0 : next_r[RW-1:0];
                end
                else
                begin
                    col_reg <= next_c[CW-1:0];
                end
            end
            if (cmd.out_load)
            begin
                ovalid_reg <= 1'b1;
                sum_reg    <= '0;
                flag_reg   <= 1'b0;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            grid_reg  <= grid_value;
            srcin_reg <= source_value;
        end
        if (cmd.win_first || cmd.win_shift)
        begin
            up_reg     <= upper_rd;
            srcold_reg <= source_rd;
        end
        if (cmd.diff)
        begin
            negx_reg <= dx[DIFFW-1];
            negy_reg <= dy[DIFFW-1];
            magx_reg <= dx[DIFFW-1] ? DIFFW'(-dx) : DIFFW'(dx);
            magy_reg <= dy[DIFFW-1] ? DIFFW'(-dy) : DIFFW'(dy);
        end
        acc_reg <= acc_next;
        if (cmd.saturate)
        begin
            if (acc_reg > SAT_HI)
                emag_reg <= SAT_HI[DW-1:0];
            else if (acc_reg < SAT_LO)
                emag_reg <= {1'b1, {(DW-1){1'b0}}};
            else if (acc_reg[ACCW-1])
                emag_reg <= DW'(-acc_reg);
            else
                emag_reg <= acc_reg[DW-1:0];
        end
        if (cmd.square)
        begin
            sq_reg <= 64'(emag_reg) * 64'(emag_reg);
        end
        if (cmd.out_load)
        begin
            norm_reg  <= sqrt_root[DW-1:0];
            oflag_reg <= flag_reg;
        end
    end

    prn_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(cmd.sqrt_start), .radicand(sum_reg),
        .done(sqrt_done), .root(sqrt_root)
    );

    assign out_valid     = ovalid_reg;
    assign residual_norm = norm_reg;
    assign overflow_seen = oflag_reg;

endmodule

/* hw/rtl/prn_ctrl.sv */
module prn_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  prn_pkg::prn_status_t status,
    output prn_pkg::prn_cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_READ  = 10'b0000000010,
        S_READ2 = 10'b0000000100,
        S_DIFF  = 10'b0000001000,
        S_MUL   = 10'b0000010000,
        S_SAT   = 10'b0000100000,
        S_SQR   = 10'b0001000000,
        S_SUM   = 10'b0010000000,
        S_ADV   = 10'b0100000000,
        S_ROOT  = 10'b1000000000
    } state_t;

    state_t              state_reg, state_next;
    prn_pkg::mul_step_t  step_reg,  step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.mul_step = step_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (status.col_zero)
                begin
                    cmd.win_first = 1'b1;
                    state_next    = S_READ2;
                end
                else
                begin
                    cmd.win_shift = 1'b1;
                    state_next    = S_DIFF;
                end
            end
            S_READ2:
            begin
                cmd.win_second = 1'b1;
                state_next     = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff  = 1'b1;
                step_next = prn_pkg::MUL_X_HI;
                state_next = status.interior ? S_MUL : S_ADV;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                case (step_reg)
                    prn_pkg::MUL_X_HI: step_next = prn_pkg::MUL_X_LO;
                    prn_pkg::MUL_X_LO: step_next = prn_pkg::MUL_Y_HI;
                    prn_pkg::MUL_Y_HI: step_next = prn_pkg::MUL_Y_LO;
                    default:           state_next = S_SAT;
                endcase
            end
            S_SAT:
            begin
                cmd.saturate = 1'b1;
                state_next   = S_SQR;
            end
            S_SQR:
            begin
                cmd.square = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_add = 1'b1;
                state_next  = S_ADV;
            end
            S_ADV:
            begin
                cmd.advance = 1'b1;
                if (status.frame_end)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_ROOT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ROOT:
            begin
                if (status.sqrt_done && status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= prn_pkg::MUL_X_HI;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

/* hw/rtl/poisson_residual_norm.sv */
// channel  direction  payload
// in_ch    sink       grid_value, source_value (signed Q16.16)
// out_ch   source     residual_norm (unsigned Q16.16), overflow_seen
// cfg      write      cfg_we, cfg_index, cfg_data
//
// Boundary points skip the multiplier; interior points (column 0 is never interior) make four
// passes through the shared multiplier. Column 0 adds a second row store read to fill the window.
// The last point of a frame also waits for the bit-serial square root.
// Reset clears position, window, sum and flag; row stores are not cleared.
// A result waits in the output register; a new frame end stalls only if it is still full.
module poisson_residual_norm #(
    parameter int MAX_ROW_LEN = prn_pkg::MAX_ROW_LEN_DEF,
    parameter int MAX_ROWS    = prn_pkg::MAX_ROWS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    prn_in_if.sink                         in_ch,
    prn_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [prn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prn_pkg::CFG_DATA_W-1:0] cfg_data
);

    prn_pkg::prn_cmd_t    cmd;
    prn_pkg::prn_status_t status;

    prn_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .status(status), .cmd(cmd)
    );

    prn_datapath #(.MAX_ROW_LEN(MAX_ROW_LEN), .MAX_ROWS(MAX_ROWS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .grid_value(in_ch.grid_value), .source_value(in_ch.source_value),
        .cmd(cmd), .status(status),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .residual_norm(out_ch.residual_norm), .overflow_seen(out_ch.overflow_seen)
    );

`ifndef NO_ASSERTIONS
    a_load_needs_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (status.sqrt_done && status.out_free))
        else $error("result loaded before root ready or slot free");
    a_mul_interior: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.diff && !status.interior |=> !cmd.mul_en)
        else $error("multiply on boundary point");
    a_root_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_start |-> status.frame_end)
        else $error("root started away from frame end");
`endif

endmodule

/* test/prn_norm_checker.sv */
module prn_norm_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    prn_in_if                              in_mon,
    prn_out_if                             out_mon,
    input  logic                           cfg_we,
    input  logic [prn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prn_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             errors,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W      = prn_pkg::DATA_W;
    localparam int DIM_W       = prn_pkg::DIM_W;
    localparam int ROW_LEN_MAX = prn_pkg::MAX_ROW_LEN_DEF;
    localparam int ROWS_MAX    = prn_pkg::MAX_ROWS_DEF;

    typedef struct packed {
        logic [DATA_W-1:0] norm;
        logic              ovf;
    } norm_beat_t;

    logic [DIM_W-1:0]  rows_cfg;
    logic [DIM_W-1:0]  len_cfg;
    logic [DATA_W-1:0] kx;
    logic [DATA_W-1:0] ky;

    logic [DATA_W-1:0] upper_mem [ROW_LEN_MAX];
    logic [DATA_W-1:0] center_mem [ROW_LEN_MAX];
    logic [DATA_W-1:0] source_mem [ROW_LEN_MAX];
    logic [DATA_W-1:0] win [3];
    logic [63:0]       sq_sum;
    int unsigned       row_pos;
    int unsigned       col_pos;
    bit                sat;

    norm_beat_t norm_q[$];

    initial
    begin
        for (int i = 0; i < ROW_LEN_MAX; i++)
        begin
            upper_mem[i]  = '0;
            center_mem[i] = '0;
            source_mem[i] = '0;
        end
        errors = 0;
    end

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // d * k / 2^16, rounded toward zero
    function automatic longint scale_q16(longint d, logic [DATA_W-1:0] k);
        logic [63:0] m;
        logic [63:0] p;
        bit          neg;
        neg = d < 0;
        m = neg ? 64'(-d) : 64'(d);
        p = (m >> 16) * 64'(k) + (((m & 64'hFFFF) * 64'(k)) >> 16);
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint sx(logic [DATA_W-1:0] v);
        return longint'($signed(v));
    endfunction

    task automatic add_term(longint up, longint mid, longint down, longint lft,
                            longint rgt, longint src);
        longint      e;
        logic [63:0] mag;
        logic [64:0] nxt;
        e = scale_q16(up + down - 2 * mid, kx) + scale_q16(lft + rgt - 2 * mid, ky) - src;
        if (e > 64'sd2147483647)
        begin
            e = 64'sd2147483647;
            sat = 1;
        end
        if (e < -64'sd2147483648)
        begin
            e = -64'sd2147483648;
            sat = 1;
        end
        mag = e < 0 ? 64'(-e) : 64'(e);
        nxt = {1'b0, sq_sum} + {1'b0, mag * mag};
        if (nxt[64])
        begin
            sq_sum = '1;
            sat = 1;
        end
        else
            sq_sum = nxt[63:0];
    endtask

    task automatic fold_point(logic [DATA_W-1:0] g, logic [DATA_W-1:0] s);
        int unsigned len;
        int unsigned rows;
        int unsigned c;
        int unsigned nc;
        norm_beat_t  b;
        logic [63:0] r64;
        len = clamp_dim(len_cfg, ROW_LEN_MAX);
        rows = clamp_dim(rows_cfg, ROWS_MAX);
        c = col_pos;
        if (c >= ROW_LEN_MAX)
            c = ROW_LEN_MAX - 1;
        nc = c + 1;
        if (c == 0)
        begin
            win[0] = '0;
            win[1] = center_mem[0];
            win[2] = center_mem[1];
        end
        else
        begin
            win[0] = win[1];
            win[1] = win[2];
            win[2] = (nc < len && nc < ROW_LEN_MAX) ? center_mem[nc] : '0;
        end
        if (row_pos >= 2 && c >= 1 && nc < len)
            add_term(sx(upper_mem[c]), sx(win[1]), sx(g), sx(win[0]), sx(win[2]),
                     sx(source_mem[c]));
        upper_mem[c] = win[1];
        center_mem[c] = g;
        source_mem[c] = s;
        if (nc >= len)
        begin
            col_pos = 0;
            if (row_pos + 1 >= rows)
            begin
                r64 = root64(sq_sum);
                b.norm = r64[DATA_W-1:0];
                b.ovf = sat;
                norm_q.push_back(b);
                sq_sum = '0;
                sat = 0;
                row_pos = 0;
            end
            else
                row_pos = row_pos + 1;
        end
        else
            col_pos = nc;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        norm_beat_t want;
        if (!rst_n)
        begin
            rows_cfg = prn_pkg::ROW_COUNT_RST;
            len_cfg = prn_pkg::ROW_LENGTH_RST;
            kx = prn_pkg::INV_D2_RST;
            ky = prn_pkg::INV_D2_RST;
            win[0] = '0;
            win[1] = '0;
            win[2] = '0;
            sq_sum = '0;
            row_pos = 0;
            col_pos = 0;
            sat = 0;
            norm_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (prn_pkg::reg_idx_t'(cfg_index))
                    prn_pkg::REG_ROW_COUNT:      rows_cfg = cfg_data[DIM_W-1:0];
                    prn_pkg::REG_ROW_LENGTH:     len_cfg = cfg_data[DIM_W-1:0];
                    prn_pkg::REG_INV_DX_SQUARED: kx = cfg_data;
                    prn_pkg::REG_INV_DY_SQUARED: ky = cfg_data;
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready)
                fold_point(in_mon.grid_value, in_mon.source_value);
            if (out_mon.valid && out_mon.ready)
            begin
                if (norm_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat: norm=%h ovf=%b",
                                 out_mon.residual_norm, out_mon.overflow_seen);
                end
                else
                begin
                    want = norm_q.pop_front();
                    if (want.norm !== out_mon.residual_norm || want.ovf !== out_mon.overflow_seen)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("result mismatch: expected norm=%h ovf=%b, got norm=%h ovf=%b",
                                     want.norm, want.ovf, out_mon.residual_norm,
                                     out_mon.overflow_seen);
                    end
                end
            end
            pending = norm_q.size();
        end
    end
endmodule

/* test/poisson_residual_norm_tb.sv */
module poisson_residual_norm_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W = prn_pkg::DATA_W;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [prn_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [prn_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             errors;
    int                             pending;
    int                             sent;
    int                             send_idle;
    int                             recv_idle;

    prn_in_if  in_ch ();
    prn_out_if out_ch ();

    poisson_residual_norm dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    prn_norm_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_mon    (in_ch),
        .out_mon   (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    initial
    begin
        #40ms;
        $display("[poisson_residual_norm] ERROR");
        $finish;
    end

    // receiver side, with one long hold-off to back the block up
    initial
    begin
        bit held;
        held = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && sent >= 200)
            begin
                held = 1;
                out_ch.ready <= 1'b0;
                repeat (2500) @(negedge clk);
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic write_reg(prn_pkg::reg_idx_t idx, logic [prn_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (60) @(negedge clk);
    endtask

    task automatic send_point(logic [DATA_W-1:0] g, logic [DATA_W-1:0] s);
        logic rdy;
        @(negedge clk);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.grid_value <= g;
        in_ch.source_value <= s;
        forever
        begin
            #1;
            rdy = in_ch.ready;
            @(posedge clk);
            if (rdy)
                break;
            @(negedge clk);
        end
        sent++;
        if (sent == 370)
        begin
            send_idle = 48;
            recv_idle = 35;
        end
        if (sent == 740)
        begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_value(int mode);
        case (mode)
            0: return $urandom_range(8 * 65536) - 4 * 65536;
            1: return $urandom;
            default:
                case ($urandom_range(4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    3: return 32'hFFFF_FFFF;
                    default: return $urandom;
                endcase
        endcase
    endfunction

    function automatic int eff_dim(int v);
        return v < 3 ? 3 : (v > 1024 ? 1024 : v);
    endfunction

    task automatic send_frame(int rows, int len, int mode);
        for (int i = 0; i < eff_dim(rows) * eff_dim(len); i++)
            send_point(pick_value(mode), pick_value(mode));
    endtask

    task automatic set_grid(int rows, int len, logic [31:0] wx, logic [31:0] wy);
        write_reg(prn_pkg::REG_ROW_COUNT, rows);
        write_reg(prn_pkg::REG_ROW_LENGTH, len);
        write_reg(prn_pkg::REG_INV_DX_SQUARED, wx);
        write_reg(prn_pkg::REG_INV_DY_SQUARED, wy);
    endtask

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0001_0000;
            3: return $urandom;
            default: return $urandom_range(4 * 65536);
        endcase
    endfunction

    initial
    begin
        int rows;
        int len;
        int mode;
        bit paused;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.grid_value = '0;
        in_ch.source_value = '0;
        sent = 0;
        send_idle = 35;
        recv_idle = 48;
        paused = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_grid(3, 3, 32'h0001_0000, 32'h0001_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h0, 32'hFFFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'h0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h0001_0000, 32'h0);
        send_point(32'hFFFF_0000, 32'h0);
        send_point(32'h0, 32'h0);
        drain();
        set_grid(3, 6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 18; i++)
            send_point(i % 2 ? 32'h7FFF_FFFF : 32'h8000_0000, 32'h8000_0000);
        drain();
        set_grid(2, 1, 32'h0, 32'h0);
        send_frame(2, 1, 0);

        while (sent < 1100)
        begin
            drain();
            rows = $urandom_range(9) == 0 ? $urandom_range(2) : $urandom_range(3, 7);
            len = $urandom_range(9) == 0 ? $urandom_range(2) : $urandom_range(3, 8);
            set_grid(rows, len, pick_weight(), pick_weight());
            repeat ($urandom_range(1, 4))
            begin
                mode = $urandom_range(9) < 6 ? 0 : ($urandom_range(1) ? 1 : 2);
                send_frame(rows, len, mode);
                if (!paused && sent >= 550)
                begin
                    paused = 1;
                    drain();
                end
            end
        end

        drain();

        if (errors == 0)
            $display("[poisson_residual_norm] OK");
        else
            $display("[poisson_residual_norm] ERROR");
        $finish;
    end
endmodule
